// ----- design/splp_pkg.sv -----
package splp_pkg;

	localparam int LEFT_W   = 16;
	localparam int RIGHT_W  = 16;
	localparam int TARGET_W = 17;
	localparam int IN_W     = 56;
	localparam int OUT_W    = 24;

	localparam int GAIN_W   = 16;
	localparam int LIMIT_W  = 16;
	localparam int CFG_W    = 16;
	localparam int CFG_IDX_W = 2;

	localparam int ERR_W    = 18;
	localparam int INTEG_W  = 17;
	localparam int SUM_W    = 19;
	localparam int MIX_W    = 22;
	localparam int DIV_W    = 21;
	localparam int DIV_CNT_W = 5;
	localparam int REM_W    = 4;
	localparam int PROD_W   = 35;
	localparam int MAC_CNT_W = 4;
	localparam int SCALE_SH = 8;
	localparam int SCALED_W = PROD_W - SCALE_SH;

	localparam logic [REM_W:0] DIVISOR = 5'd10;
	localparam logic [PROD_W-1:0] ROUND_BIAS = PROD_W'(255);

	localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_INT_LIMIT = 2'd2;

	localparam logic [GAIN_W-1:0]  GAIN_P_RESET = 16'hFD00;
	localparam logic [GAIN_W-1:0]  GAIN_I_RESET = 16'h0000;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET  = 16'd8000;

	localparam logic [OUT_W-1:0] OUT_MAX = 24'h7FFFFF;
	localparam logic [OUT_W-1:0] OUT_MIN = 24'h800000;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIV1_GO,
		ST_DIV1,
		ST_DIV2_GO,
		ST_DIV2,
		ST_INTEG,
		ST_MAC_GO,
		ST_MAC,
		ST_OUT
	} state_t;

endpackage

// ----- design/splp_div10.sv -----
module splp_div10 (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [splp_pkg::DIV_W-1:0]     dividend,
	output logic                           done,
	output logic [splp_pkg::DIV_W-1:0]     quotient
);

	logic [splp_pkg::DIV_W-1:0]     sh_q;
	logic [splp_pkg::REM_W-1:0]     rem_q;
	logic [splp_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                           busy_q;
	logic                           done_q;
	logic [splp_pkg::REM_W:0]       trial;
	logic                           ge;
	logic [splp_pkg::REM_W:0]       diff;

	assign trial = {rem_q, sh_q[splp_pkg::DIV_W-1]};
	assign ge    = (trial >= splp_pkg::DIVISOR);
	assign diff  = trial - splp_pkg::DIVISOR;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == splp_pkg::DIV_CNT_W'(splp_pkg::DIV_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sh_q  <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			sh_q  <= {sh_q[splp_pkg::DIV_W-2:0], ge};
			rem_q <= ge ? diff[splp_pkg::REM_W-1:0] : trial[splp_pkg::REM_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = sh_q;

endmodule

// ----- design/splp_mac.sv -----
module splp_mac (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic signed [splp_pkg::ERR_W-1:0]    ferr,
	input  logic signed [splp_pkg::INTEG_W-1:0]  integ,
	input  logic [splp_pkg::GAIN_W-1:0]          gain_p,
	input  logic [splp_pkg::GAIN_W-1:0]          gain_i,
	output logic                                 done,
	output logic signed [splp_pkg::PROD_W-1:0]   product
);

	logic [splp_pkg::GAIN_W-1:0]          gp_q;
	logic [splp_pkg::GAIN_W-1:0]          gi_q;
	logic signed [splp_pkg::ERR_W-1:0]    f_q;
	logic signed [splp_pkg::INTEG_W-1:0]  a_q;
	logic signed [splp_pkg::PROD_W-1:0]   p_q;
	logic [splp_pkg::MAC_CNT_W-1:0]       cnt_q;
	logic                                 busy_q;
	logic                                 done_q;
	logic signed [splp_pkg::PROD_W-1:0]   tf;
	logic signed [splp_pkg::PROD_W-1:0]   ti;
	logic signed [splp_pkg::PROD_W-1:0]   tf_raw;
	logic signed [splp_pkg::PROD_W-1:0]   ti_raw;
	logic                                 first;

	assign first  = (cnt_q == '0);
	assign tf_raw = gp_q[splp_pkg::GAIN_W-1] ? splp_pkg::PROD_W'(f_q) : '0;
	assign ti_raw = gi_q[splp_pkg::GAIN_W-1] ? splp_pkg::PROD_W'(a_q) : '0;
	assign tf     = first ? -tf_raw : tf_raw;
	assign ti     = first ? -ti_raw : ti_raw;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == splp_pkg::MAC_CNT_W'(splp_pkg::GAIN_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			gp_q <= gain_p;
			gi_q <= gain_i;
			f_q  <= ferr;
			a_q  <= integ;
			p_q  <= '0;
		end else if (busy_q) begin
			gp_q <= gp_q << 1;
			gi_q <= gi_q << 1;
			p_q  <= (p_q <<< 1) + tf + ti;
		end
	end

	assign done    = done_q;
	assign product = p_q;

endmodule

// ----- design/speed_pi_loop_with_lowpass_unit.sv -----
// Each request passes through two bit-serial divisions by ten and a bit-serial
// multiply-accumulate over the gain bits; one request is handled at a time, and the next
// is accepted only once the previous result is in the output register.
// A new request is taken while the previous result still waits on the output side.
// Reset (arst_n low, asynchronous): filter and integral state cleared, gains and
// limit back to their defaults, output empty.
module speed_pi_loop_with_lowpass_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// left_count[15:0], right_count[31:16], target_speed[48:32], zero pad[55:49]
	input  logic [splp_pkg::IN_W-1:0]         s_axis_tdata,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// drive_value[23:0]
	output logic [splp_pkg::OUT_W-1:0]        m_axis_tdata,
	input  logic                              cfg_we,
	input  logic [splp_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [splp_pkg::CFG_W-1:0]        cfg_data
);

	splp_pkg::state_t state_q, state_d;

	logic [splp_pkg::GAIN_W-1:0]          gain_p_q;
	logic [splp_pkg::GAIN_W-1:0]          gain_i_q;
	logic [splp_pkg::LIMIT_W-1:0]         limit_q;
	logic signed [splp_pkg::ERR_W-1:0]    f_q;
	logic signed [splp_pkg::INTEG_W-1:0]  integ_q;
	logic signed [splp_pkg::ERR_W-1:0]    err_q;
	logic                                 neg_q;
	logic                                 out_valid_q;
	logic [splp_pkg::OUT_W-1:0]           out_data_q;

	logic signed [splp_pkg::LEFT_W-1:0]   in_left;
	logic signed [splp_pkg::RIGHT_W-1:0]  in_right;
	logic signed [splp_pkg::TARGET_W-1:0] in_target;
	logic signed [splp_pkg::ERR_W-1:0]    err_new;

	logic signed [splp_pkg::MIX_W-1:0]    f7;
	logic signed [splp_pkg::MIX_W-1:0]    f_div;
	logic signed [splp_pkg::MIX_W-1:0]    mix;
	logic signed [splp_pkg::MIX_W-1:0]    quot_s;
	logic signed [splp_pkg::ERR_W-1:0]    f_res;
	logic signed [splp_pkg::MIX_W-1:0]    f7_abs;
	logic signed [splp_pkg::MIX_W-1:0]    mix_abs;

	logic signed [splp_pkg::SUM_W-1:0]    isum;
	logic signed [splp_pkg::SUM_W-1:0]    lim_pos;
	logic signed [splp_pkg::SUM_W-1:0]    lim_neg;
	logic signed [splp_pkg::SUM_W-1:0]    iclamp;

	logic signed [splp_pkg::PROD_W-1:0]   prod;
	logic signed [splp_pkg::PROD_W-1:0]   prod_b;
	logic signed [splp_pkg::SCALED_W-1:0] scaled;
	logic                                 fits;
	logic [splp_pkg::OUT_W-1:0]           y_sat;

	logic                                 div_start;
	logic [splp_pkg::DIV_W-1:0]           div_dividend;
	logic                                 div_done;
	logic [splp_pkg::DIV_W-1:0]           div_quot;
	logic                                 mac_start;
	logic                                 mac_done;
	logic                                 out_push;

	assign in_left   = s_axis_tdata[15:0];
	assign in_right  = s_axis_tdata[31:16];
	assign in_target = s_axis_tdata[48:32];
	assign err_new   = splp_pkg::ERR_W'(in_left) + splp_pkg::ERR_W'(in_right)
		- splp_pkg::ERR_W'(in_target);

	assign f_div   = splp_pkg::MIX_W'(f_q);
	assign f7      = (f_div <<< 3) - f_div;
	assign f7_abs  = f7[splp_pkg::MIX_W-1] ? -f7 : f7;
	assign mix     = (f_div <<< 3) + (f_div <<< 1)
		+ (splp_pkg::MIX_W'(err_q) <<< 1) + splp_pkg::MIX_W'(err_q);
	assign mix_abs = mix[splp_pkg::MIX_W-1] ? -mix : mix;

	assign quot_s = neg_q ? -$signed({1'b0, div_quot}) : $signed({1'b0, div_quot});
	assign f_res  = quot_s[splp_pkg::ERR_W-1:0];

	assign isum    = splp_pkg::SUM_W'(integ_q) + splp_pkg::SUM_W'(f_q);
	assign lim_pos = $signed({{(splp_pkg::SUM_W-splp_pkg::LIMIT_W){1'b0}}, limit_q});
	assign lim_neg = -lim_pos;
	always_comb begin
		iclamp = isum;
		if (isum > lim_pos)
			iclamp = lim_pos;
		if (isum < lim_neg)
			iclamp = lim_neg;
	end

	assign prod_b = prod[splp_pkg::PROD_W-1] ? prod + $signed(splp_pkg::ROUND_BIAS) : prod;
	assign scaled = splp_pkg::SCALED_W'(prod_b >>> splp_pkg::SCALE_SH);
	assign fits   = (&scaled[splp_pkg::SCALED_W-1:splp_pkg::OUT_W-1])
		| ~(|scaled[splp_pkg::SCALED_W-1:splp_pkg::OUT_W-1]);
	assign y_sat  = fits ? scaled[splp_pkg::OUT_W-1:0]
		: (scaled[splp_pkg::SCALED_W-1] ? splp_pkg::OUT_MIN : splp_pkg::OUT_MAX);

	splp_div10 u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.done     (div_done),
		.quotient (div_quot)
	);

	splp_mac u_mac (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mac_start),
		.ferr    (f_q),
		.integ   (integ_q),
		.gain_p  (gain_p_q),
		.gain_i  (gain_i_q),
		.done    (mac_done),
		.product (prod)
	);

	always_comb begin
		state_d       = state_q;
		s_axis_tready = 1'b0;
		div_start     = 1'b0;
		div_dividend  = f7_abs[splp_pkg::DIV_W-1:0];
		mac_start     = 1'b0;
		out_push      = 1'b0;
		case (state_q)
			splp_pkg::ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid)
					state_d = splp_pkg::ST_DIV1_GO;
			end
			splp_pkg::ST_DIV1_GO: begin
				div_start = 1'b1;
				state_d   = splp_pkg::ST_DIV1;
			end
			splp_pkg::ST_DIV1: begin
				if (div_done)
					state_d = splp_pkg::ST_DIV2_GO;
			end
			splp_pkg::ST_DIV2_GO: begin
				div_start    = 1'b1;
				div_dividend = mix_abs[splp_pkg::DIV_W-1:0];
				state_d      = splp_pkg::ST_DIV2;
			end
			splp_pkg::ST_DIV2: begin
				if (div_done)
					state_d = splp_pkg::ST_INTEG;
			end
			splp_pkg::ST_INTEG: begin
				state_d = splp_pkg::ST_MAC_GO;
			end
			splp_pkg::ST_MAC_GO: begin
				mac_start = 1'b1;
				state_d   = splp_pkg::ST_MAC;
			end
			splp_pkg::ST_MAC: begin
				if (mac_done)
					state_d = splp_pkg::ST_OUT;
			end
			splp_pkg::ST_OUT: begin
				if (!out_valid_q || m_axis_tready) begin
					out_push = 1'b1;
					state_d  = splp_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = splp_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= splp_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
			f_q         <= '0;
			integ_q     <= '0;
			gain_p_q    <= splp_pkg::GAIN_P_RESET;
			gain_i_q    <= splp_pkg::GAIN_I_RESET;
			limit_q     <= splp_pkg::LIMIT_RESET;
		end else begin
			state_q <= state_d;
			if (out_push)
				out_valid_q <= 1'b1;
			else if (m_axis_tready)
				out_valid_q <= 1'b0;
			if (cfg_we) begin
				case (cfg_index)
					splp_pkg::CFG_GAIN_P:    gain_p_q <= cfg_data;
					splp_pkg::CFG_GAIN_I:    gain_i_q <= cfg_data;
					splp_pkg::CFG_INT_LIMIT: limit_q  <= cfg_data;
					default: ;
				endcase
			end
			if ((state_q == splp_pkg::ST_DIV1 || state_q == splp_pkg::ST_DIV2) && div_done)
				f_q <= f_res;
			if (state_q == splp_pkg::ST_INTEG)
				integ_q <= iclamp[splp_pkg::INTEG_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready)
			err_q <= err_new;
		if (state_q == splp_pkg::ST_DIV1_GO)
			neg_q <= f7[splp_pkg::MIX_W-1];
		if (state_q == splp_pkg::ST_DIV2_GO)
			neg_q <= mix[splp_pkg::MIX_W-1];
		if (out_push)
			out_data_q <= y_sat;
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

endmodule

// ----- bench/tb_speed_pi_loop_with_lowpass_unit.sv -----
module tb_speed_pi_loop_with_lowpass_unit;
	import splp_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 800000;
	localparam int SETTLE_CYCLES = 80;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
	localparam int PAD_W = IN_W - LEFT_W - RIGHT_W - TARGET_W;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [IN_W-1:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [OUT_W-1:0] m_axis_tdata;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;

	logic signed [GAIN_W-1:0] gain_p_m = GAIN_P_RESET;
	logic signed [GAIN_W-1:0] gain_i_m = GAIN_I_RESET;
	logic [LIMIT_W-1:0] limit_m = LIMIT_RESET;
	logic signed [ERR_W-1:0] filt_err_m = '0;
	logic signed [INTEG_W-1:0] integ_m = '0;

	logic [OUT_W-1:0] drive_q[$];
	logic [OUT_W-1:0] drive_exp;
	int fail_count = 0;
	int unsigned cycle_count = 0;
	int rx_stall = 0;
	bit tx_idle_en = 1'b1;
	bit rx_idle_en = 1'b1;

	speed_pi_loop_with_lowpass_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	task automatic predict_drive(input logic signed [LEFT_W-1:0] left,
			input logic signed [RIGHT_W-1:0] right, input logic signed [TARGET_W-1:0] target);
		longint err;
		longint f;
		longint acc;
		longint lim;
		longint y;
		err = longint'(left) + longint'(right) - longint'(target);
		f = (longint'(filt_err_m) * 7) / 10;
		f = (f * 10 + err * 3) / 10;
		filt_err_m = ERR_W'(f);
		lim = longint'(limit_m);
		acc = longint'(integ_m) + f;
		if (acc > lim)
			acc = lim;
		if (acc < -lim)
			acc = -lim;
		integ_m = INTEG_W'(acc);
		y = (f * longint'(gain_p_m) + acc * longint'(gain_i_m)) / 256;
		if (y > 64'sd8388607)
			y = 64'sd8388607;
		if (y < -64'sd8388608)
			y = -64'sd8388608;
		drive_q.push_back(OUT_W'(y));
	endtask

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (drive_q.size() == 0) begin
				$error("drive_value: no result expected, actual %0d", $signed(m_axis_tdata));
				fail_count++;
			end else begin
				drive_exp = drive_q.pop_front();
				if (drive_exp !== m_axis_tdata) begin
					$error("drive_value: expected %0d, actual %0d",
						$signed(drive_exp), $signed(m_axis_tdata));
					fail_count++;
				end
			end
		end
		if (rx_stall > 0) begin
			rx_stall--;
			m_axis_tready <= 1'b0;
		end else if (rx_idle_en && $urandom_range(0, 7) == 0) begin
			rx_stall = $urandom_range(1, 19) - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	task automatic send_sample(input logic [LEFT_W-1:0] left, input logic [RIGHT_W-1:0] right,
			input logic [TARGET_W-1:0] target);
		int gap;
		if (tx_idle_en && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 19);
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {{PAD_W{1'b0}}, target, right, left};
		do @(posedge clk); while (!s_axis_tready);
		predict_drive(left, right, target);
	endtask

	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		while (drive_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			CFG_GAIN_P: gain_p_m = value;
			CFG_GAIN_I: gain_i_m = value;
			CFG_INT_LIMIT: limit_m = value;
			default: ;
		endcase
	endtask

	task automatic set_config(input logic [CFG_W-1:0] gp, input logic [CFG_W-1:0] gi,
			input logic [CFG_W-1:0] lim);
		write_reg(CFG_GAIN_P, gp);
		write_reg(CFG_GAIN_I, gi);
		write_reg(CFG_INT_LIMIT, lim);
	endtask

	function automatic logic [CFG_W-1:0] pick_gain();
		case ($urandom_range(0, 5))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h0000;
			3: return CFG_W'($urandom);
			default: return CFG_W'(int'($urandom_range(0, 2048)) - 1024);
		endcase
	endfunction

	function automatic logic [CFG_W-1:0] pick_limit();
		case ($urandom_range(0, 4))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return CFG_W'($urandom);
			default: return CFG_W'($urandom_range(0, 12000));
		endcase
	endfunction

	task automatic randomise_config();
		if ($urandom_range(0, 5) == 0)
			write_reg(CFG_UNUSED, CFG_W'($urandom));
		set_config(pick_gain(), pick_gain(), pick_limit());
	endtask

	task automatic send_tracking(input int base);
		int left;
		int right;
		int target;
		left = base + int'($urandom_range(0, 400)) - 200;
		right = base + int'($urandom_range(0, 400)) - 200;
		if ($urandom_range(0, 9) == 0)
			target = 2 * base + int'($urandom_range(0, 20000)) - 10000;
		else
			target = left + right + int'($urandom_range(0, 120)) - 60;
		send_sample(LEFT_W'(left), RIGHT_W'(right), TARGET_W'(target));
	endtask

	task automatic send_wide();
		send_sample(LEFT_W'($urandom), RIGHT_W'($urandom), TARGET_W'($urandom));
	endtask

	task automatic test_reset_defaults();
		send_sample(16'h0000, 16'h0000, 17'h00000);
		send_sample(16'd100, 16'd100, 17'd150);
		send_sample(16'h7FFF, 16'h7FFF, 17'h10000);
		send_sample(16'h8000, 16'h8000, 17'h0FFFF);
		send_sample(16'hFFFF, 16'h0001, 17'h1FFFF);
		send_sample(16'h0000, 16'h0000, 17'h00000);
		drain_results();
	endtask

	task automatic test_register_extremes();
		write_reg(CFG_UNUSED, 16'h1234);
		set_config(16'h7FFF, 16'h7FFF, 16'hFFFF);
		repeat (4) send_sample(16'h7FFF, 16'h7FFF, 17'h10000);
		drain_results();
		set_config(16'h8000, 16'h8000, 16'hFFFF);
		repeat (3) send_sample(16'h8000, 16'h8000, 17'h0FFFF);
		repeat (2) send_sample(16'h7FFF, 16'h7FFF, 17'h10000);
		drain_results();
		set_config(16'h8000, 16'h7FFF, 16'h0000);
		send_sample(16'h7FFF, 16'h7FFF, 17'h10000);
		send_sample(16'h8000, 16'h8000, 17'h0FFFF);
		send_sample(16'd5, 16'd5, 17'd3);
		drain_results();
		write_reg(CFG_UNUSED, 16'hFFFF);
		send_sample(16'd1, 16'd0, 17'd0);
		send_sample(16'hFFFF, 16'h0000, 17'd0);
		drain_results();
	endtask

	task automatic test_random_tracking();
		int base;
		repeat (10) begin
			randomise_config();
			base = int'($urandom_range(0, 20000)) - 10000;
			repeat (80) send_tracking(base);
			drain_results();
		end
	endtask

	task automatic test_random_wide();
		repeat (4) begin
			randomise_config();
			repeat (60) send_wide();
			drain_results();
		end
	endtask

	task automatic test_pause_for_results();
		randomise_config();
		repeat (20) send_tracking(300);
		// hold until every outstanding result is back, then resume without a config change
		s_axis_tvalid <= 1'b0;
		while (drive_q.size() != 0) @(posedge clk);
		repeat (20) send_tracking(300);
		drain_results();
	endtask

	task automatic test_quiet_tail();
		tx_idle_en = 1'b0;
		rx_idle_en = 1'b0;
		repeat (2) begin
			randomise_config();
			repeat (70) send_tracking(int'($urandom_range(0, 4000)) - 2000);
			repeat (30) send_wide();
			drain_results();
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_register_extremes();
		test_random_tracking();
		test_random_wide();
		test_pause_for_results();
		test_quiet_tail();
		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0 && drive_q.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end
endmodule

// ----- sim.f -----
design/splp_pkg.sv
design/splp_div10.sv
design/splp_mac.sv
design/speed_pi_loop_with_lowpass_unit.sv
bench/tb_speed_pi_loop_with_lowpass_unit.sv
